// ----- hdl/lss_pkg.sv -----
`default_nettype none

package lss_pkg;

    // Stack geometry
    localparam int DEPTH   = 64;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Priority encoder grouping: DEPTH is a multiple of GRP
    localparam int GRP     = 8;
    localparam int GRP_W   = $clog2(GRP);
    localparam int NGRP    = DEPTH / GRP;
    localparam int NGRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

    // Operation codes
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;
    localparam logic [1:0] MODE_SEARCH = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // Per-cycle command to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
        logic cmp;
    } t_shift;

endpackage

`default_nettype wire

// ----- hdl/lifo_stack_with_search.sv -----
`default_nettype none
// Push, pop and peek: result strobed in the cycle after the transaction, one per cycle while not busy.
// Search: result strobed once the search has passed through its stages; busy stays high
// through them (cell compare stage, then group priority encode stage).
// Reset: synchronous, active low; the stack is empty after reset, no clearing pass.
// Results are presented for one cycle and cannot be stalled by the receiver.

module lifo_stack_with_search
    import lss_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_mode,
    input  wire  [31:0] i_value,
    output logic        o_strobe,
    output logic [31:0] o_top_value,
    output logic        o_found,
    output logic [5:0]  o_found_index,
    output logic [6:0]  o_count,
    output logic        o_empty_res,
    output logic        o_full_res,
    output logic [1:0]  o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_ENCODE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_strobe;
    logic [VAL_W-1:0] r_top_value;
    logic             r_found;
    logic [IDX_W-1:0] r_found_index;
    logic [CNT_W-1:0] r_count_out;
    logic             r_empty;
    logic             r_full;
    logic [1:0]       r_status;

    logic             accept;
    logic             is_empty;
    logic             is_full;
    t_shift           ctrl;
    logic [VAL_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0] cell_vld;
    logic [DEPTH-1:0] cell_match;
    logic             enc_hit;
    logic [IDX_W-1:0] enc_pos;

    assign accept   = start & (r_state == S_IDLE);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(DEPTH));

    // Drive the chain command for this cycle
    always_comb begin
        ctrl.push = accept & (i_mode == MODE_PUSH) & ~is_full;
        ctrl.pop  = accept & (i_mode == MODE_POP) & ~is_empty;
        ctrl.cmp  = accept & (i_mode == MODE_SEARCH);
    end

    // Chain of cells: cell 0 holds the top of the stack
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [VAL_W-1:0] above_data;
        logic             above_vld;
        logic [VAL_W-1:0] below_data;
        logic             below_vld;

        if (k == 0) begin : g_top
            assign above_data = i_value[VAL_W-1:0];
            assign above_vld  = 1'b1;
        end else begin : g_mid
            assign above_data = cell_data[k-1];
            assign above_vld  = cell_vld[k-1];
        end

        if (k == DEPTH - 1) begin : g_bot
            assign below_data = '0;
            assign below_vld  = 1'b0;
        end else begin : g_up
            assign below_data = cell_data[k+1];
            assign below_vld  = cell_vld[k+1];
        end

        lss_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_key        (i_value[VAL_W-1:0]),
            .i_above_data (above_data),
            .i_above_vld  (above_vld),
            .i_below_data (below_data),
            .i_below_vld  (below_vld),
            .o_data       (cell_data[k]),
            .o_vld        (cell_vld[k]),
            .o_match      (cell_match[k])
        );
    end

    lss_encoder u_encoder (
        .i_clk   (i_clk),
        .i_match (cell_match),
        .o_hit   (enc_hit),
        .o_pos   (enc_pos)
    );

    // Sequence transactions and hold the result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_top_value   <= '0;
                        r_found       <= 1'b0;
                        r_found_index <= '0;
                        r_status      <= ST_OK;
                        case (i_mode)
                            MODE_PUSH: begin
                                r_strobe <= 1'b1;
                                if (is_full) begin
                                    r_status    <= ST_OVER;
                                    r_count_out <= r_count;
                                    r_empty     <= is_empty;
                                    r_full      <= 1'b1;
                                end else begin
                                    r_count     <= r_count + 1'b1;
                                    r_count_out <= r_count + 1'b1;
                                    r_empty     <= 1'b0;
                                    r_full      <= (r_count == CNT_W'(DEPTH - 1));
                                end
                            end
                            MODE_POP: begin
                                r_strobe <= 1'b1;
                                if (is_empty) begin
                                    r_status    <= ST_UNDER;
                                    r_count_out <= r_count;
                                    r_empty     <= 1'b1;
                                    r_full      <= 1'b0;
                                end else begin
                                    r_count     <= r_count - 1'b1;
                                    r_count_out <= r_count - 1'b1;
                                    r_empty     <= (r_count == CNT_W'(1));
                                    r_full      <= 1'b0;
                                end
                            end
                            MODE_PEEK: begin
                                r_strobe    <= 1'b1;
                                r_count_out <= r_count;
                                r_empty     <= is_empty;
                                r_full      <= is_full;
                                if (is_empty) begin
                                    r_status <= ST_UNDER;
                                end else begin
                                    r_top_value <= cell_data[0];
                                end
                            end
                            MODE_SEARCH: begin
                                r_state <= S_MATCH;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MATCH: begin
                    r_state <= S_ENCODE;
                end
                S_ENCODE: begin
                    r_state     <= S_IDLE;
                    r_strobe    <= 1'b1;
                    r_found     <= enc_hit;
                    r_count_out <= r_count;
                    r_empty     <= is_empty;
                    r_full      <= is_full;
                    // Convert distance from top into index from bottom
                    if (enc_hit) begin
                        r_found_index <= IDX_W'(r_count - CNT_W'(1) - CNT_W'(enc_pos));
                    end else begin
                        r_found_index <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_top_value   = r_top_value;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;
    assign o_count       = r_count_out;
    assign o_empty_res   = r_empty;
    assign o_full_res    = r_full;
    assign o_status      = r_status;

endmodule

`default_nettype wire

// ----- hdl/lss_cell.sv -----
`default_nettype none

module lss_cell
    import lss_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_shift           i_ctrl,
    input  wire [VAL_W-1:0]  i_key,
    input  wire [VAL_W-1:0]  i_above_data,
    input  wire              i_above_vld,
    input  wire [VAL_W-1:0]  i_below_data,
    input  wire              i_below_vld,
    output logic [VAL_W-1:0] o_data,
    output logic             o_vld,
    output logic             o_match
);

    logic [VAL_W-1:0] r_data;
    logic             r_vld;
    logic             r_match;

    // Shift data toward the bottom on push, toward the top on pop
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_above_data;
        end else if (i_ctrl.pop) begin
            r_data <= i_below_data;
        end
    end

    // Track occupancy and register the compare result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.push) begin
                r_vld <= i_above_vld;
            end else if (i_ctrl.pop) begin
                r_vld <= i_below_vld;
            end
            r_match <= i_ctrl.cmp & r_vld & (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_vld   = r_vld;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ----- hdl/lss_encoder.sv -----
`default_nettype none

module lss_encoder
    import lss_pkg::*;
(
    input  wire              i_clk,
    input  wire [DEPTH-1:0]  i_match,
    output logic             o_hit,
    output logic [IDX_W-1:0] o_pos
);

    logic [NGRP-1:0]  r_ghit;
    logic [GRP_W-1:0] r_goff [NGRP];

    logic [NGRP-1:0]  n_ghit;
    logic [GRP_W-1:0] n_goff [NGRP];

    // Find the first match in each group of cells, nearest the top
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_ghit[g] = |i_match[g*GRP +: GRP];
            n_goff[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (i_match[g*GRP + j]) begin
                    n_goff[g] = GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ghit <= n_ghit;
        r_goff <= n_goff;
    end

    // Pick the first group that hit
    always_comb begin
        logic [NGRP_W-1:0] grp;
        grp = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_ghit[g]) begin
                grp = NGRP_W'(g);
            end
        end
        o_hit = |r_ghit;
        o_pos = IDX_W'(IDX_W'(grp) * IDX_W'(GRP)) + IDX_W'(r_goff[grp]);
    end

endmodule

`default_nettype wire
